### src/sdt_pkg.sv
package sdt_pkg;

    localparam int SLOTS_DEFAULT = 16;
    localparam int ADDRESSABLE   = 16;
    localparam int CFG_ADDR_W    = 3;
    localparam int CFG_DATA_W    = 32;

    localparam logic [0:0] REG_DEFAULT_TIMEOUT = 1'b0;

    localparam logic [1:0] MODE_SCHEDULE = 2'd0;
    localparam logic [1:0] MODE_CANCEL   = 2'd1;
    localparam logic [1:0] MODE_RELEASE  = 2'd2;
    localparam logic [1:0] MODE_QUERY    = 2'd3;

    localparam logic [2:0] KIND_ARMED    = 3'd0;
    localparam logic [2:0] KIND_DISARMED = 3'd1;
    localparam logic [2:0] KIND_EXPIRED  = 3'd2;
    localparam logic [2:0] KIND_RELEASED = 3'd3;
    localparam logic [2:0] KIND_NEXT     = 3'd4;

    typedef struct packed {
        logic [1:0]  mode;
        logic [3:0]  stream_slot;
        logic [31:0] wait_ms;
        logic [63:0] now_ms;
    } sdt_in_t;

    typedef struct packed {
        logic [2:0]         kind;
        logic [3:0]         slot;
        logic signed [31:0] next_ms;
        logic               last;
    } sdt_out_t;

endpackage

### src/stream_deadline_table.sv
// stream_deadline_table: one 64-bit millisecond deadline per stream slot.
// Input beats (s_valid/s_ready, payload s_data) carry a mode, a slot, a
// timeout and the current time. Result beats (m_valid/m_ready, m_data)
// carry a kind, a slot, a time-to-next value and a last flag that marks the
// final beat caused by an input beat. The default timeout register sits at
// APB address 0; pready is always high. Write it only while the block is idle.
// One input beat is processed at a time; s_ready is low while it runs.
// Each beat passes ST_EXEC; schedule and cancel then go to ST_PUT, while
// query and release scan the table in ST_SCAN, then pass ST_DONE and
// ST_PUT. A release scans again after each expired slot it reports.
// LIMIT = min(SLOTS, 16). The table is scanned one entry per cycle through
// 64-bit comparators, so LIMIT sets the cost of each release pass and of
// a query.
// The result register lets a new beat be accepted while the last result
// still waits; a stalled receiver holds the sequencer at its next result.
// Reset disarms every slot, clears the default timeout and drops m_valid.
module stream_deadline_table #(
    parameter int SLOTS = sdt_pkg::SLOTS_DEFAULT
) (
    input  logic                                aclk,
    input  logic                                aresetn,
    input  logic                                s_valid,
    output logic                                s_ready,
    input  sdt_pkg::sdt_in_t                    s_data,
    output logic                                m_valid,
    input  logic                                m_ready,
    output sdt_pkg::sdt_out_t                   m_data,
    input  logic                                psel,
    input  logic                                penable,
    input  logic                                pwrite,
    input  logic [sdt_pkg::CFG_ADDR_W-1:0]      paddr,
    input  logic [sdt_pkg::CFG_DATA_W-1:0]      pwdata,
    output logic [sdt_pkg::CFG_DATA_W-1:0]      prdata,
    output logic                                pready
);
    import sdt_pkg::*;

    localparam int LIMIT = (SLOTS < ADDRESSABLE) ? SLOTS : ADDRESSABLE;
    localparam int IDX_W = $clog2(LIMIT);

    localparam logic [2:0] ST_IDLE = 3'd0;
    localparam logic [2:0] ST_EXEC = 3'd1;
    localparam logic [2:0] ST_SCAN = 3'd2;
    localparam logic [2:0] ST_DONE = 3'd3;
    localparam logic [2:0] ST_PUT  = 3'd4;

    logic [2:0]       state_reg, state_next;
    logic [2:0]       after_reg, after_next;
    sdt_in_t          item_reg, item_next;
    logic [31:0]      dflt_reg, dflt_next;
    logic [LIMIT-1:0] armed_reg, armed_next;
    logic [63:0]      deadline_reg [LIMIT];
    logic [IDX_W-1:0] idx_reg, idx_next;
    logic [IDX_W-1:0] best_reg, best_next;
    logic [63:0]      best_dl_reg, best_dl_next;
    logic             found_reg, found_next;
    sdt_out_t         res_reg, res_next;
    logic             m_valid_reg, m_valid_next;
    sdt_out_t         m_data_reg, m_data_next;

    logic             dl_we;
    logic [63:0]      dl_wdata;
    logic [IDX_W-1:0] slot_idx;
    logic             slot_ok;
    logic [31:0]      to_sel;
    logic [64:0]      sum;
    logic [63:0]      cur_dl;
    logic [63:0]      diff;
    logic             cand;
    logic             can_load;
    logic             cfg_wr;

    assign pready   = 1'b1;
    assign cfg_wr   = psel && penable && pwrite;
    assign prdata   = (paddr[CFG_ADDR_W-1] == REG_DEFAULT_TIMEOUT) ? dflt_reg : '0;
    assign s_ready  = (state_reg == ST_IDLE);
    assign m_valid  = m_valid_reg;
    assign m_data   = m_data_reg;
    assign can_load = !m_valid_reg || m_ready;

    assign slot_idx = item_reg.stream_slot[IDX_W-1:0];
    assign slot_ok  = 5'(item_reg.stream_slot) < 5'(LIMIT);
    assign to_sel   = (item_reg.wait_ms != '0) ? item_reg.wait_ms : dflt_reg;
    assign sum      = {1'b0, item_reg.now_ms} + {33'd0, to_sel};
    assign dl_wdata = sum[64] ? '1 : sum[63:0];
    assign cur_dl   = deadline_reg[idx_reg];
    assign diff     = best_dl_reg - item_reg.now_ms;
    assign cand     = armed_reg[idx_reg]
                      && (item_reg.mode == MODE_QUERY || cur_dl <= item_reg.now_ms)
                      && (!found_reg || cur_dl < best_dl_reg);

    always_comb begin
        state_next   = state_reg;
        after_next   = after_reg;
        item_next    = item_reg;
        dflt_next    = dflt_reg;
        armed_next   = armed_reg;
        idx_next     = idx_reg;
        best_next    = best_reg;
        best_dl_next = best_dl_reg;
        found_next   = found_reg;
        res_next     = res_reg;
        m_valid_next = m_valid_reg;
        m_data_next  = m_data_reg;
        dl_we        = 1'b0;

        if (cfg_wr && paddr[CFG_ADDR_W-1] == REG_DEFAULT_TIMEOUT) begin
            dflt_next = pwdata;
        end
        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        case (state_reg)
            ST_IDLE: begin
                if (s_valid) begin
                    item_next  = s_data;
                    state_next = ST_EXEC;
                end
            end
            ST_EXEC: begin
                idx_next   = '0;
                found_next = 1'b0;
                res_next   = '{kind: KIND_DISARMED, slot: item_reg.stream_slot,
                               next_ms: '0, last: 1'b1};
                if (item_reg.mode == MODE_SCHEDULE || item_reg.mode == MODE_CANCEL) begin
                    if (slot_ok) begin
                        armed_next[slot_idx] = 1'b0;
                        if (item_reg.mode == MODE_SCHEDULE && to_sel != '0) begin
                            armed_next[slot_idx] = 1'b1;
                            dl_we                = 1'b1;
                            res_next.kind        = KIND_ARMED;
                        end
                    end
                    after_next = ST_IDLE;
                    state_next = ST_PUT;
                end else begin
                    state_next = ST_SCAN;
                end
            end
            ST_SCAN: begin
                if (cand) begin
                    found_next   = 1'b1;
                    best_next    = idx_reg;
                    best_dl_next = cur_dl;
                end
                if (idx_reg == IDX_W'(LIMIT - 1)) begin
                    state_next = ST_DONE;
                end else begin
                    idx_next = idx_reg + 1'b1;
                end
            end
            ST_DONE: begin
                idx_next   = '0;
                found_next = 1'b0;
                after_next = ST_IDLE;
                res_next   = '{kind: KIND_RELEASED, slot: '0, next_ms: '0, last: 1'b1};
                if (item_reg.mode == MODE_RELEASE) begin
                    if (found_reg) begin
                        armed_next[best_reg] = 1'b0;
                        res_next.kind        = KIND_EXPIRED;
                        res_next.slot        = 4'(best_reg);
                        res_next.last        = 1'b0;
                        after_next           = ST_SCAN;
                    end
                end else begin
                    res_next.kind = KIND_NEXT;
                    if (!found_reg) begin
                        res_next.next_ms = '1;
                    end else if (best_dl_reg < item_reg.now_ms) begin
                        res_next.next_ms = '0;
                    end else if (diff[63:31] != '0) begin
                        res_next.next_ms = 32'sh7FFF_FFFF;
                    end else begin
                        res_next.next_ms = 32'(diff[30:0]);
                    end
                end
                state_next = ST_PUT;
            end
            ST_PUT: begin
                if (can_load) begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_reg;
                    state_next   = after_reg;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= ST_IDLE;
            after_reg   <= ST_IDLE;
            dflt_reg    <= '0;
            armed_reg   <= '0;
            found_reg   <= 1'b0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            after_reg   <= after_next;
            dflt_reg    <= dflt_next;
            armed_reg   <= armed_next;
            found_reg   <= found_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg    <= item_next;
        idx_reg     <= idx_next;
        best_reg    <= best_next;
        best_dl_reg <= best_dl_next;
        res_reg     <= res_next;
        m_data_reg  <= m_data_next;
        if (dl_we) begin
            deadline_reg[slot_idx] <= dl_wdata;
        end
    end

endmodule

### src/sdt_checker.sv
module sdt_checker (
    input logic              aclk,
    input logic              aresetn,
    input logic              s_valid,
    input logic              s_ready,
    input logic              m_valid,
    input logic              m_ready,
    input sdt_pkg::sdt_out_t m_data
);
    import sdt_pkg::*;

    // stalled result beat holds
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_ready |=> m_valid && $stable(m_data))
        else $error("result beat changed under stall");

    // only expired-slot beats are non-final
    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && !m_data.last |-> m_data.kind == KIND_EXPIRED)
        else $error("non-final beat of wrong kind");

    assert property (@(posedge aclk) disable iff (!aresetn)
        m_valid && m_data.kind != KIND_NEXT |-> m_data.next_ms == 0)
        else $error("next_ms set on non-query beat");

    // one beat in flight at a time
    assert property (@(posedge aclk) disable iff (!aresetn)
        s_valid && s_ready |=> !s_ready)
        else $error("input accepted while busy");

endmodule

bind stream_deadline_table sdt_checker u_sdt_checker (
    .aclk    (aclk),
    .aresetn (aresetn),
    .s_valid (s_valid),
    .s_ready (s_ready),
    .m_valid (m_valid),
    .m_ready (m_ready),
    .m_data  (m_data)
);
